// File: src/modbus_rtu_receive_framer_unit_defines.svh
// Assertion macros shared by the receive framer modules.
`ifndef MODBUS_RTU_RECEIVE_FRAMER_UNIT_DEFINES_SVH
`define MODBUS_RTU_RECEIVE_FRAMER_UNIT_DEFINES_SVH

`ifndef SYNTH
// Checked property, disabled while reset is asserted.
`define MBRX_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("mbrx assertion failed");
// Checked property, evaluated during reset too.
`define MBRX_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) (prop)) \
    else $error("mbrx assertion failed");
`else
`define MBRX_ASSERT(lbl, prop)
`define MBRX_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

// File: src/mbrx_pkg.sv
// Types, constants and the CRC helper of the Modbus RTU receive framer.
package mbrx_pkg;

  localparam int BUFFER_BYTES    = 256;
  localparam int MIN_FRAME_BYTES = 4;
  localparam int FRAME_OVERHEAD  = 4;

  localparam int ADDR_W = $clog2(BUFFER_BYTES);
  localparam int CNT_W  = $clog2(BUFFER_BYTES + 1);
  localparam int POS_W  = 9;
  localparam int APB_AW = 3;

  localparam logic [7:0]  OWN_ADDR_RST  = 8'd1;
  localparam logic [15:0] SILENCE_RST   = 16'd40;
  localparam logic [15:0] CRC_PRESET    = 16'hFFFF;
  localparam logic [15:0] CRC_RESIDUE   = 16'h0000;
  localparam logic [15:0] CRC_POLY      = 16'hA001;
  localparam logic [7:0]  BCAST_ADDR    = 8'h00;

  // Register index taken from paddr[2]
  localparam logic REG_OWN_ADDRESS   = 1'b0;
  localparam logic REG_SILENCE_TICKS = 1'b1;

  typedef enum logic [1:0] {
    MODE_INIT = 2'd0,
    MODE_IDLE = 2'd1,
    MODE_RECV = 2'd2,
    MODE_ERR  = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    OP_BYTE    = 2'd0,
    OP_TICK    = 2'd1,
    OP_READ    = 2'd2,
    OP_RESTART = 2'd3
  } opcode_e;

  typedef enum logic [2:0] {
    ST_NONE     = 3'd0,
    ST_OK       = 3'd1,
    ST_BAD      = 3'd2,
    ST_NOT_ADDR = 3'd3,
    ST_READ     = 3'd4
  } status_e;

  typedef struct packed {
    status_e    status;
    logic [7:0] frame_address;
    logic [7:0] function_code;
    logic [7:0] pdu_length;
    logic       rd_sel;
  } mbrx_res_t;

  function automatic logic [15:0] crc_fold(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// File: src/mbrx_ram.sv
// Generic single-write, single-read RAM with registered read data.
module mbrx_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: src/mbrx_ctrl.sv
// Receive control: mode, frame count, running CRC, silence timer, store access.
`include "modbus_rtu_receive_framer_unit_defines.svh"
module mbrx_ctrl import mbrx_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              fire_i,
  input  logic [1:0]        opcode_i,
  input  logic [7:0]        rx_byte_i,
  input  logic [7:0]        pdu_index_i,
  input  logic [7:0]        own_address_i,
  input  logic [15:0]       silence_ticks_i,
  output logic              ram_we_o,
  output logic [ADDR_W-1:0] ram_waddr_o,
  output logic [7:0]        ram_wdata_o,
  output logic              ram_re_o,
  output logic [ADDR_W-1:0] ram_raddr_o,
  output mbrx_res_t         res_o
);

  mode_e             mode_q, mode_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [15:0]       crc_q, crc_d;
  logic [15:0]       tmr_q, tmr_d;
  logic              armed_q, armed_d;
  logic [7:0]        addr_q, addr_d;
  logic [7:0]        fc_q, fc_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_INIT;
      cnt_q   <= '0;
      crc_q   <= CRC_PRESET;
      tmr_q   <= SILENCE_RST;
      armed_q <= 1'b1;
    end else begin
      mode_q  <= mode_d;
      cnt_q   <= cnt_d;
      crc_q   <= crc_d;
      tmr_q   <= tmr_d;
      armed_q <= armed_d;
    end
  end

  // Address and function code mirror store entries 0 and 1 for the verdict
  always_ff @(posedge clk_i) begin
    addr_q <= addr_d;
    fc_q   <= fc_d;
  end

  always_comb begin
    logic [CNT_W-1:0] base_cnt;
    logic [15:0]      base_crc;
    logic [POS_W-1:0] pos;

    mode_d      = mode_q;
    cnt_d       = cnt_q;
    crc_d       = crc_q;
    tmr_d       = tmr_q;
    armed_d     = armed_q;
    addr_d      = addr_q;
    fc_d        = fc_q;
    ram_we_o    = 1'b0;
    ram_waddr_o = cnt_q[ADDR_W-1:0];
    ram_wdata_o = rx_byte_i;
    ram_re_o    = 1'b0;
    res_o       = '0;
    base_cnt    = (mode_q == MODE_IDLE) ? '0 : cnt_q;
    base_crc    = (mode_q == MODE_IDLE) ? CRC_PRESET : crc_q;
    pos         = {1'b0, pdu_index_i} + POS_W'(2);
    ram_raddr_o = pos[ADDR_W-1:0];

    if (fire_i) begin
      unique case (opcode_e'(opcode_i))
        OP_BYTE: begin
          tmr_d   = silence_ticks_i;
          armed_d = 1'b1;
          if (mode_q == MODE_IDLE || mode_q == MODE_RECV) begin
            mode_d = MODE_RECV;
            cnt_d  = base_cnt;
            crc_d  = base_crc;
            if (base_cnt < CNT_W'(BUFFER_BYTES)) begin
              ram_we_o    = 1'b1;
              ram_waddr_o = base_cnt[ADDR_W-1:0];
              cnt_d       = base_cnt + CNT_W'(1);
              crc_d       = crc_fold(base_crc, rx_byte_i);
              if (base_cnt == CNT_W'(0)) begin
                addr_d = rx_byte_i;
              end
              if (base_cnt == CNT_W'(1)) begin
                fc_d = rx_byte_i;
              end
            end else begin
              // Store full: drop the beat
              mode_d = MODE_ERR;
            end
          end
        end
        OP_TICK: begin
          if (armed_q) begin
            if (tmr_q <= 16'd1) begin
              tmr_d   = '0;
              armed_d = 1'b0;
              mode_d  = MODE_IDLE;
              if (mode_q == MODE_RECV) begin
                if (cnt_q < CNT_W'(MIN_FRAME_BYTES) || crc_q != CRC_RESIDUE) begin
                  res_o.status = ST_BAD;
                end else if (addr_q != own_address_i && addr_q != BCAST_ADDR) begin
                  res_o.status = ST_NOT_ADDR;
                end else begin
                  res_o.status        = ST_OK;
                  res_o.frame_address = addr_q;
                  res_o.function_code = fc_q;
                  res_o.pdu_length    = 8'(cnt_q - CNT_W'(FRAME_OVERHEAD));
                end
              end
            end else begin
              tmr_d = tmr_q - 16'd1;
            end
          end
        end
        OP_READ: begin
          res_o.status = ST_READ;
          if (pos < POS_W'(BUFFER_BYTES)) begin
            ram_re_o     = 1'b1;
            res_o.rd_sel = 1'b1;
          end
        end
        OP_RESTART: begin
          mode_d  = MODE_INIT;
          tmr_d   = silence_ticks_i;
          armed_d = 1'b1;
        end
        default: begin
          mode_d = mode_q;
        end
      endcase
    end
  end

  `MBRX_ASSERT(a_disarmed_zero, !armed_q |-> tmr_q == 16'd0)
  `MBRX_ASSERT(a_cnt_bound, cnt_q <= CNT_W'(BUFFER_BYTES))
  `MBRX_ASSERT(a_ok_needs_recv, res_o.status == ST_OK |-> mode_q == MODE_RECV && fire_i)

endmodule

// File: src/mbrx_out.sv
// Result stage after the store read, followed by the output register.
`include "modbus_rtu_receive_framer_unit_defines.svh"
module mbrx_out import mbrx_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       fire_i,
  input  mbrx_res_t  res_i,
  input  logic [7:0] ram_rdata_i,
  output logic       take_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [2:0] status_o,
  output logic [7:0] frame_address_o,
  output logic [7:0] function_code_o,
  output logic [7:0] pdu_length_o,
  output logic [7:0] read_data_o
);

  logic      s1_v_q, s1_v_d;
  mbrx_res_t s1_q;
  logic      out_v_q, out_v_d;
  logic [2:0] status_q;
  logic [7:0] addr_q, fc_q, plen_q, rdata_q;
  logic      adv;

  // Read data stays in the RAM register while this stage stalls: no new read
  // can be issued then.
  assign adv     = s1_v_q && (!out_v_q || out_ready_i);
  assign take_o  = !s1_v_q || adv;
  assign s1_v_d  = fire_i || (s1_v_q && !adv);
  assign out_v_d = adv || (out_v_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      s1_v_q  <= s1_v_d;
      out_v_q <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire_i) begin
      s1_q <= res_i;
    end
    if (adv) begin
      status_q <= s1_q.status;
      addr_q   <= s1_q.frame_address;
      fc_q     <= s1_q.function_code;
      plen_q   <= s1_q.pdu_length;
      rdata_q  <= s1_q.rd_sel ? ram_rdata_i : 8'h00;
    end
  end

  assign out_valid_o     = out_v_q;
  assign status_o        = status_q;
  assign frame_address_o = addr_q;
  assign function_code_o = fc_q;
  assign pdu_length_o    = plen_q;
  assign read_data_o     = rdata_q;

  `MBRX_ASSERT(a_s1_held, s1_v_q && out_v_q && !out_ready_i |=> s1_v_q)
  `MBRX_ASSERT(a_no_overrun, fire_i |-> take_o)
  `MBRX_ASSERT_ALWAYS(a_rst_empty, !rst_ni |-> !out_valid_o)

endmodule

// File: src/modbus_rtu_receive_framer_unit.sv
// Modbus RTU receive framer: frames serial bytes by line silence, checks
// length, CRC and address, and answers reads of the stored PDU. One item is
// accepted per clock cycle unless a stalled output holds the result stage;
// each returns exactly one result beat via the result stage, which waits on
// the registered store read port, and then the output register. Effects on
// mode, count, CRC and timer are complete in the accept cycle, so a read may
// follow a byte directly. own_address is at byte address 0, silence_ticks at 4.
module modbus_rtu_receive_framer_unit import mbrx_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [1:0]        opcode_i,
  input  logic [7:0]        rx_byte_i,
  input  logic [7:0]        pdu_index_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [2:0]        status_o,
  output logic [7:0]        frame_address_o,
  output logic [7:0]        function_code_o,
  output logic [7:0]        pdu_length_o,
  output logic [7:0]        read_data_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  logic [7:0]        own_address_q;
  logic [15:0]       silence_ticks_q;
  logic              cfg_wr;
  logic              fire;
  logic              take;
  logic              ram_we, ram_re;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr;
  logic [7:0]        ram_wdata, ram_rdata;
  mbrx_res_t         res;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_address_q   <= OWN_ADDR_RST;
      silence_ticks_q <= SILENCE_RST;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_OWN_ADDRESS) begin
        own_address_q <= pwdata[7:0];
      end else begin
        silence_ticks_q <= pwdata[15:0];
      end
    end
  end

  assign prdata = (paddr[2] == REG_SILENCE_TICKS) ? {16'h0000, silence_ticks_q}
                                                  : {24'h000000, own_address_q};

  assign in_ready_o = take;
  assign fire       = in_valid_i && take;

  mbrx_ctrl u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .fire_i          (fire),
    .opcode_i        (opcode_i),
    .rx_byte_i       (rx_byte_i),
    .pdu_index_i     (pdu_index_i),
    .own_address_i   (own_address_q),
    .silence_ticks_i (silence_ticks_q),
    .ram_we_o        (ram_we),
    .ram_waddr_o     (ram_waddr),
    .ram_wdata_o     (ram_wdata),
    .ram_re_o        (ram_re),
    .ram_raddr_o     (ram_raddr),
    .res_o           (res)
  );

  mbrx_ram #(
    .WIDTH (8),
    .DEPTH (BUFFER_BYTES)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  mbrx_out u_out (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .fire_i          (fire),
    .res_i           (res),
    .ram_rdata_i     (ram_rdata),
    .take_o          (take),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .status_o        (status_o),
    .frame_address_o (frame_address_o),
    .function_code_o (function_code_o),
    .pdu_length_o    (pdu_length_o),
    .read_data_o     (read_data_o)
  );

endmodule
